FILE: rtl/mstt_pkg.sv
// Shared constants, codes, types and the saturating subtract for the timeout timer.
package mstt_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_MAX     = (SLOT_COUNT > MAX_RESULTS) ? SLOT_COUNT : MAX_RESULTS;
    localparam int CNT_W       = $clog2(CNT_MAX + 1);

    localparam int ACT_W  = 3;
    localparam int ID_W   = 16;
    localparam int DUR_W  = 32;
    localparam int ELAP_W = 16;
    localparam int REM_W  = 33;
    localparam int STS_W  = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_START   = 3'd0,
        ACT_RESTART = 3'd1,
        ACT_STOP    = 3'd2,
        ACT_QUERY   = 3'd3,
        ACT_TICK    = 3'd4
    } t_action;

    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
    localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_CMD,
        S_SUB,
        S_SEARCH,
        S_FIRE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [DUR_W-1:0]  dur;
        logic [REM_W-1:0]  rem;
    } t_slot_rd;

    typedef struct packed {
        logic [SLOT_W-1:0] idx;
        logic              entry_we;
        logic              rem_we;
        logic              clr;
        logic [ID_W-1:0]   id;
        logic [DUR_W-1:0]  dur;
        logic [REM_W-1:0]  rem;
    } t_slot_wr;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic              armed;
        logic              fired;
        logic [ID_W-1:0]   fired_id;
        logic              last;
    } t_result;

    // Subtracts the elapsed time and saturates at the most negative remaining value.
    function automatic logic [REM_W-1:0] sub_sat(input logic [REM_W-1:0] rem,
                                                 input logic [ELAP_W-1:0] elapsed);
        logic [REM_W:0] diff;
        diff = {rem[REM_W-1], rem} - {{(REM_W + 1 - ELAP_W){1'b0}}, elapsed};
        if (diff[REM_W] && !diff[REM_W-1]) begin
            sub_sat = {1'b1, {(REM_W - 1){1'b0}}};
        end else begin
            sub_sat = diff[REM_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/mstt_slot_store.sv
// Slot table: valid bits, ids, durations and remaining times with one read and one write port.
module mstt_slot_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mstt_pkg::SLOT_W-1:0] i_rd_idx,
    output mstt_pkg::t_slot_rd        o_rd,
    input  mstt_pkg::t_slot_wr        i_wr
);
    import mstt_pkg::*;

    logic [SLOT_COUNT-1:0] r_valid;
    logic [ID_W-1:0]       r_id  [SLOT_COUNT];
    logic [DUR_W-1:0]      r_dur [SLOT_COUNT];
    logic [REM_W-1:0]      r_rem [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.entry_we) begin
            r_valid[i_wr.idx] <= 1'b1;
        end else if (i_wr.clr) begin
            r_valid[i_wr.idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.entry_we) begin
            r_id[i_wr.idx]  <= i_wr.id;
            r_dur[i_wr.idx] <= i_wr.dur;
            r_rem[i_wr.idx] <= i_wr.rem;
        end else if (i_wr.rem_we) begin
            r_rem[i_wr.idx] <= i_wr.rem;
        end
    end

    assign o_rd.valid = r_valid[i_rd_idx];
    assign o_rd.id    = r_id[i_rd_idx];
    assign o_rd.dur   = r_dur[i_rd_idx];
    assign o_rd.rem   = r_rem[i_rd_idx];

endmodule

FILE: rtl/multi_slot_timeout_timer.sv
// Top level of the timeout timer: command sequencer, slot scans and result register.
//
//   Channel   Handshake                  Payload
//   input     i_in_valid / o_in_ready    i_action, i_timer_id, i_duration_ms, i_elapsed_ms
//   output    o_out_valid / i_out_ready  o_status, o_armed, o_fired, o_fired_id, o_last
//
// Start, restart, stop and query scan the slot table once, one slot per cycle, and then
// load their result into the output register.
// A tick makes one subtract pass over the table and then, for each expiry, a full
// minimum search through the one slot read port.
// Reset clears the valid bits at once, so no clearing pass follows it.
// A stalled output holds the sequencer in its emit state; no request is taken meanwhile.
module multi_slot_timeout_timer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [mstt_pkg::ACT_W-1:0]  i_action,
    input  logic [mstt_pkg::ID_W-1:0]   i_timer_id,
    input  logic [mstt_pkg::DUR_W-1:0]  i_duration_ms,
    input  logic [mstt_pkg::ELAP_W-1:0] i_elapsed_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [mstt_pkg::STS_W-1:0]  o_status,
    output logic                        o_armed,
    output logic                        o_fired,
    output logic [mstt_pkg::ID_W-1:0]   o_fired_id,
    output logic                        o_last
);
    import mstt_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

    t_state            r_state, n_state;
    t_action           r_action;
    logic [ID_W-1:0]   r_id;
    logic [DUR_W-1:0]  r_dur;
    logic [ELAP_W-1:0] r_elapsed;
    logic [SLOT_W-1:0] r_idx;
    logic              r_hit, r_free, r_bfound;
    logic [SLOT_W-1:0] r_hit_idx, r_free_idx, r_best_idx;
    logic [REM_W-1:0]  r_best_rem;
    logic [CNT_W-1:0]  r_cnt, r_total, r_n;
    t_result           r_res, r_out;
    logic              r_out_valid;

    logic              in_ready, out_free, load_out, scan_end;
    logic [SLOT_W-1:0] rd_idx;
    t_slot_rd          rd;
    t_slot_wr          wr;
    logic [REM_W-1:0]  sub_res;
    logic              sub_le0, rd_le0, rd_lt_best, is_cand;
    logic [CNT_W-1:0]  n_cnt;

    mstt_slot_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (rd_idx),
        .o_rd     (rd),
        .i_wr     (wr)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign scan_end   = (r_idx == LAST_IDX);
    assign sub_res    = sub_sat(rd.rem, r_elapsed);
    assign sub_le0    = sub_res[REM_W-1] || (sub_res == '0);
    assign rd_le0     = rd.rem[REM_W-1] || (rd.rem == '0);
    assign rd_lt_best = $signed(rd.rem) < $signed(r_best_rem);
    assign is_cand    = rd.valid && rd_le0 && (!r_bfound || rd_lt_best);
    assign n_cnt      = r_cnt + CNT_W'(rd.valid && sub_le0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_action)
                        ACT_START, ACT_RESTART, ACT_STOP, ACT_QUERY: n_state = S_FIND;
                        ACT_TICK: n_state = S_SUB;
                        default:  n_state = S_OUT;
                    endcase
                end
            end
            S_FIND: begin
                if (scan_end) begin
                    n_state = S_CMD;
                end
            end
            S_CMD: n_state = S_OUT;
            S_SUB: begin
                if (scan_end) begin
                    n_state = (n_cnt == '0) ? S_OUT : S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (scan_end) begin
                    n_state = S_FIRE;
                end
            end
            S_FIRE: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = r_res.last ? S_IDLE : S_SEARCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready    = 1'b0;
        load_out    = 1'b0;
        rd_idx      = r_idx;
        wr          = '0;
        wr.id       = r_id;
        wr.dur      = r_dur;
        wr.rem      = {1'b0, r_dur};
        case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_CMD: begin
                rd_idx = r_hit ? r_hit_idx : r_free_idx;
                case (r_action)
                    ACT_START:   wr.entry_we = r_hit || r_free;
                    ACT_RESTART: begin
                        wr.rem_we = r_hit;
                        wr.rem    = {1'b0, rd.dur};
                    end
                    ACT_STOP:    wr.clr = r_hit;
                    default:     wr.clr = 1'b0;
                endcase
            end
            S_SUB: begin
                wr.rem_we = rd.valid;
                wr.rem    = sub_res;
            end
            S_FIRE: begin
                rd_idx = r_best_idx;
                wr.clr = 1'b1;
            end
            S_OUT: load_out = out_free;
            default: load_out = 1'b0;
        endcase
        wr.idx = rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_action  <= t_action'(i_action);
                    r_id      <= i_timer_id;
                    r_dur     <= i_duration_ms;
                    r_elapsed <= i_elapsed_ms;
                    r_idx     <= '0;
                    r_hit     <= 1'b0;
                    r_free    <= 1'b0;
                    r_cnt     <= '0;
                    r_n       <= '0;
                    r_res     <= '{status: STS_OK, armed: 1'b0, fired: 1'b0,
                                   fired_id: '0, last: 1'b1};
                end
            end
            S_FIND: begin
                r_idx <= scan_end ? '0 : r_idx + 1'b1;
                if (rd.valid && (rd.id == r_id) && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_idx;
                end
                if (!rd.valid && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_idx;
                end
            end
            S_CMD: begin
                case (r_action)
                    ACT_START:   r_res.status <= (r_hit || r_free) ? STS_OK : STS_FULL;
                    ACT_RESTART, ACT_STOP: r_res.status <= r_hit ? STS_OK : STS_NOT_FOUND;
                    ACT_QUERY:   r_res.armed <= r_hit;
                    default:     r_res.status <= STS_OK;
                endcase
            end
            S_SUB: begin
                r_idx <= scan_end ? '0 : r_idx + 1'b1;
                r_cnt <= n_cnt;
                if (scan_end) begin
                    r_total  <= (n_cnt > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : n_cnt;
                    r_bfound <= 1'b0;
                end
            end
            S_SEARCH: begin
                r_idx <= scan_end ? '0 : r_idx + 1'b1;
                if (is_cand) begin
                    r_bfound   <= 1'b1;
                    r_best_idx <= r_idx;
                    r_best_rem <= rd.rem;
                end
            end
            S_FIRE: begin
                r_res    <= '{status: STS_OK, armed: 1'b0, fired: 1'b1, fired_id: rd.id,
                              last: (CNT_W'(r_n + 1'b1) == r_total)};
                r_n      <= r_n + 1'b1;
                r_idx    <= '0;
                r_bfound <= 1'b0;
            end
            default: r_idx <= r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_armed     = r_out.armed;
    assign o_fired     = r_out.fired;
    assign o_fired_id  = r_out.fired_id;
    assign o_last      = r_out.last;

endmodule

FILE: rtl/mstt_checker.sv
// Port-level checks for the timeout timer and the bind that attaches them.
module mstt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic [mstt_pkg::STS_W-1:0]  o_status,
    input  logic                        o_armed,
    input  logic                        o_fired,
    input  logic [mstt_pkg::ID_W-1:0]   o_fired_id,
    input  logic                        o_last
);
    import mstt_pkg::*;

    // A request occupies the sequencer, so the next cycle takes none.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while the previous one was in progress");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_fired_id) && $stable(o_last))
        else $error("result changed while stalled");

    a_fire_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fired |-> (o_status == STS_OK) && !o_armed)
        else $error("expiry result with status or armed set");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_fired |-> o_last && (o_fired_id == '0))
        else $error("non-expiry result not final");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind multi_slot_timeout_timer mstt_checker u_mstt_checker (.*);

FILE: verif/tb_multi_slot_timeout_timer.sv
// Self-checking testbench for the multi-slot timeout timer with a predicting scoreboard.
`timescale 1ns / 100ps

module tb_multi_slot_timeout_timer;

    import mstt_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;
    localparam int               ITEM_TARGET      = 380;
    localparam int               CALM_FROM        = 320;
    localparam int               DRAIN_CYCLES     = 60;
    localparam int               ID_POOL_SIZE     = 24;

    class timer_scoreboard;
        bit                valid_tab [SLOT_COUNT];
        logic [ID_W-1:0]   id_tab    [SLOT_COUNT];
        logic [DUR_W-1:0]  dur_tab   [SLOT_COUNT];
        longint            rem_tab   [SLOT_COUNT];
        t_result           expected_q[$];
        int                errors;
        int                checked;
        int                requests;
        int                expiries;
        int                rejects;

        function void clear_table();
            int i;
            for (i = 0; i < SLOT_COUNT; i++) begin
                valid_tab[i] = 1'b0;
                rem_tab[i]   = 0;
            end
            errors   = 0;
            checked  = 0;
            requests = 0;
            expiries = 0;
            rejects  = 0;
        endfunction

        function int find_id(logic [ID_W-1:0] id);
            int i;
            for (i = 0; i < SLOT_COUNT; i++) begin
                if (valid_tab[i] && id_tab[i] == id) begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void push(logic [STS_W-1:0] status, logic armed, logic fired,
                           logic [ID_W-1:0] fid, logic last);
            t_result r;
            r.status   = status;
            r.armed    = armed;
            r.fired    = fired;
            r.fired_id = fid;
            r.last     = last;
            expected_q = {expected_q, r};
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                   logic [DUR_W-1:0] dur, logic [ELAP_W-1:0] elapsed);
            int     i;
            int     s;
            int     best;
            int     n;
            longint floor_val;
            floor_val = -64'sd4294967296;
            requests++;
            s = find_id(id);
            if (act == ACT_START) begin
                if (s < 0) begin
                    for (i = 0; i < SLOT_COUNT; i++) begin
                        if (s < 0 && !valid_tab[i]) begin
                            s = i;
                        end
                    end
                end
                if (s < 0) begin
                    rejects++;
                    push(STS_FULL, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    valid_tab[s] = 1'b1;
                    id_tab[s]    = id;
                    dur_tab[s]   = dur;
                    rem_tab[s]   = longint'({32'd0, dur});
                    push(STS_OK, 1'b0, 1'b0, '0, 1'b1);
                end
            end else if (act == ACT_RESTART || act == ACT_STOP) begin
                if (s < 0) begin
                    push(STS_NOT_FOUND, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    if (act == ACT_RESTART) begin
                        rem_tab[s] = longint'({32'd0, dur_tab[s]});
                    end else begin
                        valid_tab[s] = 1'b0;
                    end
                    push(STS_OK, 1'b0, 1'b0, '0, 1'b1);
                end
            end else if (act == ACT_QUERY) begin
                push(STS_OK, (s >= 0), 1'b0, '0, 1'b1);
            end else if (act == ACT_TICK) begin
                for (i = 0; i < SLOT_COUNT; i++) begin
                    if (valid_tab[i]) begin
                        rem_tab[i] = rem_tab[i] - longint'({48'd0, elapsed});
                        if (rem_tab[i] < floor_val) begin
                            rem_tab[i] = floor_val;
                        end
                    end
                end
                n = 0;
                while (n < MAX_RESULTS) begin
                    best = -1;
                    for (i = 0; i < SLOT_COUNT; i++) begin
                        if (valid_tab[i] && rem_tab[i] <= 0 &&
                            (best < 0 || rem_tab[i] < rem_tab[best])) begin
                            best = i;
                        end
                    end
                    if (best < 0) begin
                        break;
                    end
                    valid_tab[best] = 1'b0;
                    push(STS_OK, 1'b0, 1'b1, id_tab[best], 1'b0);
                    expiries++;
                    n++;
                end
                if (n == 0) begin
                    push(STS_OK, 1'b0, 1'b0, '0, 1'b1);
                end else begin
                    expected_q[expected_q.size() - 1].last = 1'b1;
                end
            end else begin
                push(STS_OK, 1'b0, 1'b0, '0, 1'b1);
            end
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            if (errors <= 40) begin
                $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                         $time, what, got, want);
            end
        endtask

        task check_result(logic [STS_W-1:0] status, logic armed, logic fired,
                          logic [ID_W-1:0] fid, logic last);
            t_result want;
            checked++;
            if (expected_q.size() == 0) begin
                report("unexpected result", {status, armed, fired, fid, last}, 0);
            end else begin
                want = expected_q.pop_front();
                if (status !== want.status) report("status", status, want.status);
                if (armed !== want.armed) report("armed", armed, want.armed);
                if (fired !== want.fired) report("fired", fired, want.fired);
                if (fid !== want.fired_id) report("fired_id", fid, want.fired_id);
                if (last !== want.last) report("last", last, want.last);
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [ACT_W-1:0]  i_action;
    logic [ID_W-1:0]   i_timer_id;
    logic [DUR_W-1:0]  i_duration_ms;
    logic [ELAP_W-1:0] i_elapsed_ms;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [STS_W-1:0]  o_status;
    logic              o_armed;
    logic              o_fired;
    logic [ID_W-1:0]   o_fired_id;
    logic              o_last;

    timer_scoreboard   sb;
    bit                idle_on;
    int                items_sent;
    int                stall_left;
    logic [ID_W-1:0]   id_pool [ID_POOL_SIZE];

    multi_slot_timeout_timer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_timer_id    (i_timer_id),
        .i_duration_ms (i_duration_ms),
        .i_elapsed_ms  (i_elapsed_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_armed       (o_armed),
        .o_fired       (o_fired),
        .o_fired_id    (o_fired_id),
        .o_last        (o_last)
    );

    always #10 i_clk = ~i_clk;

    task automatic send_request(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                                logic [DUR_W-1:0] dur, logic [ELAP_W-1:0] elapsed);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_timer_id    <= id;
        i_duration_ms <= dur;
        i_elapsed_ms  <= elapsed;
        do begin
            @(posedge i_clk);
        end while (o_in_ready !== 1'b1);
        sb.note_request(act, id, dur, elapsed);
        items_sent++;
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 9) == 0) begin
            return ID_W'($urandom);
        end
        return id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return '0;
        end else if (r < 80) begin
            return $urandom_range(0, 200000);
        end
        return $urandom;
    endfunction

    task automatic random_request();
        int                r;
        logic [ACT_W-1:0]  act;
        logic [ELAP_W-1:0] elapsed;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            act = ACT_START;
        end else if (r < 45) begin
            act = ACT_RESTART;
        end else if (r < 55) begin
            act = ACT_STOP;
        end else if (r < 70) begin
            act = ACT_QUERY;
        end else if (r < 97) begin
            act = ACT_TICK;
        end else begin
            act = ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
        end
        if ($urandom_range(0, 1) == 0) begin
            elapsed = ELAP_W'($urandom);
        end else begin
            elapsed = ELAP_W'($urandom_range(0, 5000));
        end
        send_request(act, pick_id(), pick_duration(), elapsed);
    endtask

    // Starts 16 to 19 timers to fill the table, then sends a query, a maximal tick and a random tick.
    task automatic fill_table();
        int k;
        int count;
        count = $urandom_range(16, 19);
        for (k = 0; k < count; k++) begin
            send_request(ACT_START, ($urandom_range(0, 3) == 0) ? pick_id() : ID_W'($urandom),
                         $urandom_range(0, 60000), ELAP_W'($urandom));
        end
        send_request(ACT_QUERY, pick_id(), $urandom, ELAP_W'($urandom));
        send_request(ACT_TICK, ID_W'($urandom), $urandom, 16'hFFFF);
        send_request(ACT_TICK, ID_W'($urandom), $urandom, ELAP_W'($urandom_range(0, 65535)));
    endtask

    initial begin
        i_out_ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                sb.check_result(o_status, o_armed, o_fired, o_fired_id, o_last);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 8);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        #15_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int  a;
        int  k;
        bit  paused;
        sb = new();
        sb.clear_table();
        idle_on    = 1'b1;
        items_sent = 0;
        paused     = 1'b0;
        for (k = 0; k < ID_POOL_SIZE; k++) begin
            id_pool[k] = ID_W'($urandom);
        end
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_QUERY;
        i_timer_id    <= '0;
        i_duration_ms <= '0;
        i_elapsed_ms  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(ACT_TICK, 16'h0000, 32'h0, 16'h0000);
        send_request(ACT_QUERY, 16'h0000, 32'h0, 16'h0000);
        send_request(ACT_RESTART, 16'h1234, 32'h0, 16'h0000);
        send_request(ACT_STOP, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(ACT_START, 16'h0000, 32'h0, 16'h0000);
        send_request(ACT_START, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
        send_request(ACT_QUERY, 16'hFFFF, 32'h0, 16'h0000);
        send_request(ACT_START, 16'hFFFF, 32'd100, 16'h0000);
        send_request(ACT_TICK, 16'h0000, 32'h0, 16'h0000);
        send_request(ACT_START, 16'h0005, 32'd100, 16'h0000);
        send_request(ACT_TICK, 16'h0000, 32'h0, 16'd150);
        for (a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++) begin
            send_request(ACT_W'(a), 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        end
        send_request(ACT_START, 16'h0007, 32'd50, 16'h0000);
        send_request(ACT_TICK, 16'h0000, 32'h0, 16'd30);
        send_request(ACT_RESTART, 16'h0007, 32'h0, 16'h0000);
        send_request(ACT_TICK, 16'h0000, 32'h0, 16'd30);
        send_request(ACT_STOP, 16'h0007, 32'h0, 16'h0000);
        send_request(ACT_TICK, 16'h0000, 32'h0, 16'hFFFF);

        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= CALM_FROM) begin
                idle_on = 1'b0;
            end
            if (!paused && items_sent >= 200) begin
                paused = 1'b1;
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (sb.pending() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 29) == 0) begin
                fill_table();
            end else begin
                if ($urandom_range(0, 49) == 0) begin
                    id_pool[$urandom_range(0, ID_POOL_SIZE - 1)] = ID_W'($urandom);
                end
                random_request();
            end
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: %0d results checked, %0d expiries, %0d full-table rejects.",
                 sb.requests, sb.checked, sb.expiries, sb.rejects);
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/mstt_pkg.sv
rtl/mstt_slot_store.sv
rtl/multi_slot_timeout_timer.sv
rtl/mstt_checker.sv
verif/tb_multi_slot_timeout_timer.sv
